// ===== src/assert_macros.svh =====
// Assertion macros used by the queue core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/tlgq_pkg.sv =====
// Package with the sizes, codes and types of the two-level group queue.
package tlgq_pkg;
    localparam int QUEUE_DEPTH = 256;
    localparam int GROUP_COUNT = 1024;
    localparam int SUPER_COUNT = 1024;
    localparam int MAX_POP     = 64;
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUP_W     = $clog2(GROUP_COUNT);
    localparam int SUPER_W     = $clog2(SUPER_COUNT);
    localparam int CLEAR_COUNT = (GROUP_COUNT > SUPER_COUNT) ?
        ((GROUP_COUNT > QUEUE_DEPTH) ? GROUP_COUNT : QUEUE_DEPTH) :
        ((SUPER_COUNT > QUEUE_DEPTH) ? SUPER_COUNT : QUEUE_DEPTH);
    localparam int CLEAR_W     = $clog2(CLEAR_COUNT + 1);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } last_ent_t;

    typedef struct packed {
        logic [15:0]        item;
        logic [GROUP_W-1:0] group;
        logic [SUPER_W-1:0] sup;
    } entry_t;
endpackage

// ===== src/two_level_group_queue_core.sv =====
// Top level of the two-level group queue: linked store, tail tables and sequencer.
//
// After reset the block clears its group and supergroup tail tables and
// chains the free list, with s_ready low. An insert passes S_INS1, S_INS2 and
// S_INS3, a full-store drop S_FULL; a remove passes S_REM0, S_REM1 and S_REM2
// for each entry returned, set by the dependent reads of the entry, link and
// tail tables, each a synchronous memory with a registered read. Results leave
// through an output register, so a slow consumer stalls the sequencer.
`include "assert_macros.svh"

module two_level_group_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_item_id,
    input  logic [9:0]  s_group_id,
    input  logic [9:0]  s_super_id,
    input  logic [6:0]  s_pop_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_item,
    output logic [1:0]  m_status,
    output logic        m_last
);
    localparam int SW = tlgq_pkg::SLOT_W;
    localparam int FW = tlgq_pkg::FILL_W;
    localparam int GW = tlgq_pkg::GROUP_W;
    localparam int UW = tlgq_pkg::SUPER_W;
    localparam int CW = tlgq_pkg::CLEAR_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FULL, S_EMPTY,
        S_INS1, S_INS2, S_INS3, S_REM0, S_REM1, S_REM2
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [15:0] item_reg, item_next;
    logic [GW-1:0] group_reg, group_next;
    logic [UW-1:0] super_reg, super_next;
    logic [6:0] want_reg, want_next, cnt_reg, cnt_next;
    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next, free_reg, free_next;
    logic [SW-1:0] slot_reg, slot_next, pred_reg, pred_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [15:0] m_item_reg, m_item_next;
    logic [1:0] m_status_reg, m_status_next;

    tlgq_pkg::entry_t ent_mem [tlgq_pkg::QUEUE_DEPTH];
    logic [SW-1:0] link_mem [tlgq_pkg::QUEUE_DEPTH];
    tlgq_pkg::last_ent_t grp_mem [tlgq_pkg::GROUP_COUNT];
    tlgq_pkg::last_ent_t sup_mem [tlgq_pkg::SUPER_COUNT];

    tlgq_pkg::entry_t ent_rd, ent_wd;
    logic [SW-1:0] link_rd, link_wd, link_wa, link_ra, ent_wa, ent_ra;
    tlgq_pkg::last_ent_t grp_rd, grp_wd, sup_rd, sup_wd;
    logic [GW-1:0] grp_wa, grp_ra;
    logic [UW-1:0] sup_wa, sup_ra;
    logic ent_we, ent_re, link_we, link_re, grp_we, grp_re, sup_we, sup_re;
    logic out_free;
    logic [6:0] pop_sat;

    assign out_free = !m_valid_reg || m_ready;
    assign pop_sat = (s_pop_count > 7'(tlgq_pkg::MAX_POP)) ?
        7'(tlgq_pkg::MAX_POP) : s_pop_count;

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        item_next = item_reg;
        group_next = group_reg;
        super_next = super_reg;
        want_next = want_reg;
        cnt_next = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        free_next = free_reg;
        slot_next = slot_reg;
        pred_next = pred_reg;
        fill_next = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next = m_item_reg;
        m_status_next = m_status_reg;
        m_last_next = m_last_reg;
        ent_we = 1'b0; ent_re = 1'b0; link_we = 1'b0; link_re = 1'b0;
        grp_we = 1'b0; grp_re = 1'b0; sup_we = 1'b0; sup_re = 1'b0;
        ent_wa = slot_reg; ent_ra = head_reg;
        ent_wd = '{item: item_reg, group: group_reg, sup: super_reg};
        link_wa = slot_reg; link_wd = '0; link_ra = free_reg;
        grp_wa = group_reg; grp_wd = '0; grp_ra = group_reg;
        sup_wa = super_reg; sup_wd = '0; sup_ra = super_reg;
        s_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                grp_we = (clr_reg < CW'(tlgq_pkg::GROUP_COUNT));
                grp_wa = clr_reg[GW-1:0];
                sup_we = (clr_reg < CW'(tlgq_pkg::SUPER_COUNT));
                sup_wa = clr_reg[UW-1:0];
                link_we = (clr_reg < CW'(tlgq_pkg::QUEUE_DEPTH));
                link_wa = clr_reg[SW-1:0];
                link_wd = clr_reg[SW-1:0] + SW'(1);
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(tlgq_pkg::CLEAR_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_item_id;
                    group_next = s_group_id[GW-1:0];
                    super_next = s_super_id[UW-1:0];
                    want_next = pop_sat;
                    cnt_next = '0;
                    if (s_kind == tlgq_pkg::KIND_REMOVE) begin
                        state_next = (pop_sat == 7'd0) ? S_IDLE : S_REM0;
                    end else if (fill_reg == FW'(tlgq_pkg::QUEUE_DEPTH)) begin
                        state_next = S_FULL;
                    end else begin
                        slot_next = free_reg;
                        link_re = 1'b1;
                        grp_re = 1'b1;
                        grp_ra = s_group_id[GW-1:0];
                        sup_re = 1'b1;
                        sup_ra = s_super_id[UW-1:0];
                        state_next = S_INS1;
                    end
                end
            end
            S_FULL, S_EMPTY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next = '0;
                    m_status_next = (state_reg == S_FULL) ?
                        tlgq_pkg::ST_FULL : tlgq_pkg::ST_EMPTY;
                    m_last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INS1: begin
                free_next = link_rd;
                ent_we = 1'b1;
                if (fill_reg == '0) begin
                    pred_next = slot_reg;
                end else if (grp_rd.valid) begin
                    pred_next = grp_rd.slot;
                end else if (sup_rd.valid) begin
                    pred_next = sup_rd.slot;
                end else begin
                    pred_next = tail_reg;
                end
                link_re = 1'b1;
                link_ra = pred_next;
                state_next = S_INS2;
            end
            S_INS2: begin
                link_we = 1'b1;
                link_wa = slot_reg;
                link_wd = (fill_reg == '0) ? '0 : link_rd;
                state_next = S_INS3;
            end
            S_INS3: begin
                if (out_free) begin
                    link_we = (fill_reg != '0);
                    link_wa = pred_reg;
                    link_wd = slot_reg;
                    grp_we = 1'b1;
                    grp_wd = '{valid: 1'b1, slot: slot_reg};
                    sup_we = !sup_rd.valid || sup_rd.slot == pred_reg || fill_reg == '0;
                    sup_wd = '{valid: 1'b1, slot: slot_reg};
                    if (fill_reg == '0) begin
                        head_next = slot_reg;
                        tail_next = slot_reg;
                    end else if (pred_reg == tail_reg) begin
                        tail_next = slot_reg;
                    end
                    fill_next = fill_reg + FW'(1);
                    m_valid_next = 1'b1;
                    m_item_next = '0;
                    m_status_next = tlgq_pkg::ST_INSERTED;
                    m_last_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM0: begin
                if (fill_reg == '0) begin
                    state_next = S_EMPTY;
                end else begin
                    ent_re = 1'b1;
                    link_re = 1'b1;
                    link_ra = head_reg;
                    state_next = S_REM1;
                end
            end
            S_REM1: begin
                grp_re = 1'b1;
                grp_ra = ent_rd.group;
                sup_re = 1'b1;
                sup_ra = ent_rd.sup;
                state_next = S_REM2;
            end
            S_REM2: begin
                if (out_free) begin
                    grp_we = grp_rd.valid && grp_rd.slot == head_reg;
                    grp_wa = ent_rd.group;
                    sup_we = sup_rd.valid && sup_rd.slot == head_reg;
                    sup_wa = ent_rd.sup;
                    link_we = 1'b1;
                    link_wa = head_reg;
                    link_wd = free_reg;
                    free_next = head_reg;
                    fill_next = fill_reg - FW'(1);
                    if (fill_reg == FW'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end else begin
                        head_next = link_rd;
                    end
                    m_valid_next = 1'b1;
                    m_item_next = ent_rd.item;
                    m_status_next = tlgq_pkg::ST_REMOVED;
                    m_last_next = (cnt_reg + 7'd1 == want_reg);
                    cnt_next = cnt_reg + 7'd1;
                    state_next = (cnt_reg + 7'd1 == want_reg) ? S_IDLE : S_REM0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            ent_rd <= ent_mem[ent_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re) begin
            link_rd <= link_mem[link_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_we) begin
            grp_mem[grp_wa] <= grp_wd;
        end
        if (grp_re) begin
            grp_rd <= grp_mem[grp_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (sup_we) begin
            sup_mem[sup_wa] <= sup_wd;
        end
        if (sup_re) begin
            sup_rd <= sup_mem[sup_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            free_reg <= '0;
            fill_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
            fill_reg <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg <= item_next;
        group_reg <= group_next;
        super_reg <= super_next;
        want_reg <= want_next;
        cnt_reg <= cnt_next;
        slot_reg <= slot_next;
        pred_reg <= pred_next;
        m_item_reg <= m_item_next;
        m_status_reg <= m_status_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_item = m_item_reg;
    assign m_status = m_status_reg;
    assign m_last = m_last_reg;

    `ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_reg <= FW'(tlgq_pkg::QUEUE_DEPTH))
    `ASSERT_ALWAYS(a_empty_ptrs, aclk, aresetn, fill_reg != '0 || (head_reg == '0 && tail_reg == '0))
    `ASSERT_ALWAYS(a_no_accept_clear, aclk, aresetn, !(state_reg == S_CLEAR && s_ready))
    `ASSERT_NEXT(a_insert_result, aclk, aresetn, state_reg == S_INS3 && out_free, m_valid && m_status == tlgq_pkg::ST_INSERTED)
endmodule
